### sv/ccfr_pkg.sv
package ccfr_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CRC_W   = 16;
    localparam int unsigned GROUP_W = 3;
    localparam int unsigned PHASE_W = 3;

    localparam logic [PHASE_W-1:0] PH_HUNT = 3'd0;
    localparam logic [PHASE_W-1:0] PH_AA   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_REG  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LEN  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DATA = 3'd4;
    localparam logic [PHASE_W-1:0] PH_CRCH = 3'd5;
    localparam logic [PHASE_W-1:0] PH_CRCL = 3'd6;

    localparam logic ITEM_PAYLOAD   = 1'b0;
    localparam logic ITEM_FRAME_END = 1'b1;

    localparam logic [BYTE_W-1:0] PREAMBLE_FIRST  = 8'hFF;
    localparam logic [BYTE_W-1:0] PREAMBLE_SECOND = 8'hAA;
    localparam logic [CRC_W-1:0]  CRC_INIT        = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY        = 16'h1021;

    localparam logic [GROUP_W-1:0] GRP_NETWORK    = 3'd0;
    localparam logic [GROUP_W-1:0] GRP_MINING     = 3'd1;
    localparam logic [GROUP_W-1:0] GRP_MONITORING = 3'd2;
    localparam logic [GROUP_W-1:0] GRP_DEVICE     = 3'd3;
    localparam logic [GROUP_W-1:0] GRP_API        = 3'd4;
    localparam logic [GROUP_W-1:0] GRP_FLAGS      = 3'd5;
    localparam logic [GROUP_W-1:0] GRP_SPECIAL    = 3'd6;
    localparam logic [GROUP_W-1:0] GRP_UNKNOWN    = 3'd7;

    typedef struct packed {
        logic               item_kind;
        logic [BYTE_W-1:0]  reg_addr;
        logic [BYTE_W-1:0]  payload_byte;
        logic [BYTE_W-1:0]  byte_index;
        logic [BYTE_W-1:0]  payload_len;
        logic [GROUP_W-1:0] handler_group;
        logic [CRC_W-1:0]   frame_crc;
        logic               crc_ok;
        logic               last;
    } t_result;

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [GROUP_W-1:0] group_of(input logic [BYTE_W-1:0] r);
        logic [GROUP_W-1:0] g;
        if (r inside {[8'h21:8'h26]}) begin
            g = GRP_NETWORK;
        end else if (r inside {[8'h30:8'h35]}) begin
            g = GRP_MINING;
        end else if (r inside {[8'h40:8'h46]}) begin
            g = GRP_MONITORING;
        end else if (r inside {[8'h50:8'h54], [8'h70:8'h74]}) begin
            g = GRP_DEVICE;
        end else if (r inside {[8'h60:8'h6C]}) begin
            g = GRP_API;
        end else if (r inside {[8'hE0:8'hEF]}) begin
            g = GRP_FLAGS;
        end else if (r inside {[8'hF0:8'hFF]}) begin
            g = GRP_SPECIAL;
        end else begin
            g = GRP_UNKNOWN;
        end
        return g;
    endfunction

endpackage

### sv/crc_checked_frame_receiver_unit.sv
// Receives serial bytes, hunts for the preamble FF AA (repeated FF keeps the hunt armed),
// then takes register, length, payload and a big-endian CRC-16 (init FFFF, poly 1021,
// MSB first, over register, length and payload). Each payload byte leaves as a payload
// item; after the second CRC byte a frame-end item carries register, handler group,
// length, received CRC and crc_ok. The frame is consumed whether the CRC matches or not.
// One byte is taken every cycle; a byte waits in the input register and its result
// is held in the result register. That rate is set by the combinational byte-wide CRC
// update into the CRC register; only a stalled result register holds off new bytes.
module crc_checked_frame_receiver_unit
    import ccfr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rx_valid,
    output logic               o_rx_ready,
    input  logic [BYTE_W-1:0]  i_rx_byte,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic               o_item_kind,
    output logic [BYTE_W-1:0]  o_reg_addr,
    output logic [BYTE_W-1:0]  o_payload_byte,
    output logic [BYTE_W-1:0]  o_byte_index,
    output logic [BYTE_W-1:0]  o_payload_len,
    output logic [GROUP_W-1:0] o_handler_group,
    output logic [CRC_W-1:0]   o_frame_crc,
    output logic               o_crc_ok,
    output logic               o_last
);

    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;

    logic [PHASE_W-1:0] r_phase,    n_phase;
    logic [BYTE_W-1:0]  r_frame_reg, n_frame_reg;
    logic [BYTE_W-1:0]  r_frame_len, n_frame_len;
    logic [BYTE_W-1:0]  r_count,    n_count;
    logic [CRC_W-1:0]   r_crc,      n_crc;
    logic [BYTE_W-1:0]  r_crc_high, n_crc_high;

    logic               r_out_valid;
    t_result            r_out, n_out;

    logic               res_hit;
    logic               out_free;
    logic               proc_fire;
    logic [CRC_W-1:0]   crc_upd;
    logic [CRC_W-1:0]   rx_crc;
    logic [BYTE_W-1:0]  count_inc;

    assign out_free   = !r_out_valid || i_res_ready;
    assign res_hit    = (r_phase == PH_DATA) || (r_phase == PH_CRCL);
    assign proc_fire  = r_in_valid && (!res_hit || out_free);
    assign o_rx_ready = !r_in_valid || proc_fire;

    assign crc_upd   = crc_byte(r_crc, r_in_byte);
    assign rx_crc    = {r_crc_high, r_in_byte};
    assign count_inc = r_count + 1'b1;

    always_comb begin
        n_phase     = r_phase;
        n_frame_reg = r_frame_reg;
        n_frame_len = r_frame_len;
        n_count     = r_count;
        n_crc       = r_crc;
        n_crc_high  = r_crc_high;
        n_out       = '0;
        n_out.reg_addr      = r_frame_reg;
        n_out.payload_len   = r_frame_len;
        n_out.handler_group = group_of(r_frame_reg);
        case (r_phase)
            PH_AA: begin
                if (r_in_byte == PREAMBLE_SECOND) begin
                    n_phase = PH_REG;
                    n_crc   = CRC_INIT;
                end else if (r_in_byte != PREAMBLE_FIRST) begin
                    n_phase = PH_HUNT;
                end
            end
            PH_REG: begin
                n_frame_reg = r_in_byte;
                n_crc       = crc_upd;
                n_phase     = PH_LEN;
            end
            PH_LEN: begin
                n_frame_len = r_in_byte;
                n_count     = '0;
                n_crc       = crc_upd;
                n_phase     = (r_in_byte == '0) ? PH_CRCH : PH_DATA;
            end
            PH_DATA: begin
                n_crc              = crc_upd;
                n_out.item_kind    = ITEM_PAYLOAD;
                n_out.payload_byte = r_in_byte;
                n_out.byte_index   = r_count;
                n_count            = count_inc;
                if (count_inc == r_frame_len) begin
                    n_phase = PH_CRCH;
                end
            end
            PH_CRCH: begin
                n_crc_high = r_in_byte;
                n_phase    = PH_CRCL;
            end
            PH_CRCL: begin
                n_out.item_kind = ITEM_FRAME_END;
                n_out.frame_crc = rx_crc;
                n_out.crc_ok    = (rx_crc == r_crc);
                n_out.last      = 1'b1;
                n_phase         = PH_HUNT;
            end
            default: begin
                n_phase = (r_in_byte == PREAMBLE_FIRST) ? PH_AA : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= PH_HUNT;
            r_out_valid <= 1'b0;
        end else begin
            if (o_rx_ready) begin
                r_in_valid <= i_rx_valid;
            end
            if (proc_fire) begin
                r_phase <= n_phase;
            end
            if (proc_fire && res_hit) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (proc_fire) begin
            r_frame_reg <= n_frame_reg;
            r_frame_len <= n_frame_len;
            r_count     <= n_count;
            r_crc       <= n_crc;
            r_crc_high  <= n_crc_high;
        end
        if (proc_fire && res_hit) begin
            r_out <= n_out;
        end
    end

    assign o_res_valid     = r_out_valid;
    assign o_item_kind     = r_out.item_kind;
    assign o_reg_addr      = r_out.reg_addr;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_byte_index    = r_out.byte_index;
    assign o_payload_len   = r_out.payload_len;
    assign o_handler_group = r_out.handler_group;
    assign o_frame_crc     = r_out.frame_crc;
    assign o_crc_ok        = r_out.crc_ok;
    assign o_last          = r_out.last;

endmodule

### sv/ccfr_checker.sv
module ccfr_checker
    import ccfr_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_res_valid,
    input logic               i_res_ready,
    input logic               o_item_kind,
    input logic [BYTE_W-1:0]  o_payload_byte,
    input logic [BYTE_W-1:0]  o_byte_index,
    input logic [BYTE_W-1:0]  o_payload_len,
    input logic [CRC_W-1:0]   o_frame_crc,
    input logic               o_crc_ok,
    input logic               o_last
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

    a_last_marks_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_last == (o_item_kind == ITEM_FRAME_END)))
        else $error("last flag disagrees with item kind");

    a_index_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_item_kind == ITEM_PAYLOAD) |->
            (o_byte_index < o_payload_len) && (o_frame_crc == '0) && !o_crc_ok)
        else $error("payload item out of frame bounds");

    a_end_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_item_kind == ITEM_FRAME_END) |->
            (o_payload_byte == '0) && (o_byte_index == '0))
        else $error("frame end item carries payload data");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=>
            o_res_valid && $stable(o_payload_byte) && $stable(o_frame_crc))
        else $error("stalled result changed");

endmodule

bind crc_checked_frame_receiver_unit ccfr_checker u_ccfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_res_valid    (o_res_valid),
    .i_res_ready    (i_res_ready),
    .o_item_kind    (o_item_kind),
    .o_payload_byte (o_payload_byte),
    .o_byte_index   (o_byte_index),
    .o_payload_len  (o_payload_len),
    .o_frame_crc    (o_frame_crc),
    .o_crc_ok       (o_crc_ok),
    .o_last         (o_last)
);

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import ccfr_pkg::*;

    class frame_scoreboard;
        logic [PHASE_W-1:0] phase;
        logic [BYTE_W-1:0]  frame_reg;
        logic [BYTE_W-1:0]  frame_len;
        logic [BYTE_W-1:0]  data_count;
        logic [CRC_W-1:0]   crc_acc;
        logic [BYTE_W-1:0]  crc_hi;
        t_result            expected_q[$];
        int unsigned        errors;

        function new();
            phase      = PH_HUNT;
            frame_reg  = '0;
            frame_len  = '0;
            data_count = '0;
            crc_acc    = CRC_INIT;
            crc_hi     = '0;
            errors     = 0;
        endfunction

        function logic [CRC_W-1:0] crc_step(logic [CRC_W-1:0] crc, logic [BYTE_W-1:0] b);
            logic fb;
            for (int i = BYTE_W - 1; i >= 0; i--) begin
                fb  = crc[CRC_W-1] ^ b[i];
                crc = crc << 1;
                if (fb) begin
                    crc = crc ^ CRC_POLY;
                end
            end
            return crc;
        endfunction

        function logic [GROUP_W-1:0] reg_group(logic [BYTE_W-1:0] r);
            if (r >= 8'hF0) return GRP_SPECIAL;
            if (r >= 8'hE0 && r <= 8'hEF) return GRP_FLAGS;
            if (r >= 8'h70 && r <= 8'h74) return GRP_DEVICE;
            if (r >= 8'h60 && r <= 8'h6C) return GRP_API;
            if (r >= 8'h50 && r <= 8'h54) return GRP_DEVICE;
            if (r >= 8'h40 && r <= 8'h46) return GRP_MONITORING;
            if (r >= 8'h30 && r <= 8'h35) return GRP_MINING;
            if (r >= 8'h21 && r <= 8'h26) return GRP_NETWORK;
            return GRP_UNKNOWN;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_input(logic [BYTE_W-1:0] b);
            t_result r;
            r = '0;
            case (phase)
                PH_AA: begin
                    if (b == PREAMBLE_SECOND) begin
                        phase   = PH_REG;
                        crc_acc = CRC_INIT;
                    end else if (b != PREAMBLE_FIRST) begin
                        phase = PH_HUNT;
                    end
                end
                PH_REG: begin
                    frame_reg = b;
                    crc_acc   = crc_step(crc_acc, b);
                    phase     = PH_LEN;
                end
                PH_LEN: begin
                    frame_len  = b;
                    data_count = '0;
                    crc_acc    = crc_step(crc_acc, b);
                    phase      = (b == 0) ? PH_CRCH : PH_DATA;
                end
                PH_DATA: begin
                    crc_acc         = crc_step(crc_acc, b);
                    r.item_kind     = ITEM_PAYLOAD;
                    r.reg_addr      = frame_reg;
                    r.payload_byte  = b;
                    r.byte_index    = data_count;
                    r.payload_len   = frame_len;
                    r.handler_group = reg_group(frame_reg);
                    expected_q.push_back(r);
                    data_count = data_count + 1'b1;
                    if (data_count == frame_len) begin
                        phase = PH_CRCH;
                    end
                end
                PH_CRCH: begin
                    crc_hi = b;
                    phase  = PH_CRCL;
                end
                PH_CRCL: begin
                    r.item_kind     = ITEM_FRAME_END;
                    r.reg_addr      = frame_reg;
                    r.payload_len   = frame_len;
                    r.handler_group = reg_group(frame_reg);
                    r.frame_crc     = {crc_hi, b};
                    r.crc_ok        = ({crc_hi, b} == crc_acc);
                    r.last          = 1'b1;
                    expected_q.push_back(r);
                    phase = PH_HUNT;
                end
                default: begin
                    phase = (b == PREAMBLE_FIRST) ? PH_AA : PH_HUNT;
                end
            endcase
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task compare(string field, logic [CRC_W-1:0] got, logic [CRC_W-1:0] want);
            if (got !== want) begin
                report($sformatf("%s got %h want %h", field, got, want));
            end
        endtask

        task check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected item %h", got));
            end else begin
                want = expected_q.pop_front();
                compare("item_kind", CRC_W'(got.item_kind), CRC_W'(want.item_kind));
                compare("reg_addr", CRC_W'(got.reg_addr), CRC_W'(want.reg_addr));
                compare("payload_byte", CRC_W'(got.payload_byte),
                        CRC_W'(want.payload_byte));
                compare("byte_index", CRC_W'(got.byte_index), CRC_W'(want.byte_index));
                compare("payload_len", CRC_W'(got.payload_len), CRC_W'(want.payload_len));
                compare("handler_group", CRC_W'(got.handler_group),
                        CRC_W'(want.handler_group));
                compare("frame_crc", got.frame_crc, want.frame_crc);
                compare("crc_ok", CRC_W'(got.crc_ok), CRC_W'(want.crc_ok));
                compare("last", CRC_W'(got.last), CRC_W'(want.last));
            end
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               rx_valid = 1'b0;
    logic               rx_ready;
    logic [BYTE_W-1:0]  rx_byte = '0;
    logic               res_valid;
    logic               res_ready = 1'b0;
    logic               item_kind;
    logic [BYTE_W-1:0]  reg_addr;
    logic [BYTE_W-1:0]  payload_byte;
    logic [BYTE_W-1:0]  byte_index;
    logic [BYTE_W-1:0]  payload_len;
    logic [GROUP_W-1:0] handler_group;
    logic [CRC_W-1:0]   frame_crc;
    logic               crc_ok;
    logic               last;

    frame_scoreboard    sb = new();
    logic [BYTE_W-1:0]  payload_q[$];
    bit                 tx_steady = 1'b0;
    bit                 hold_req = 1'b0;
    int unsigned        frame_bytes = 0;

    crc_checked_frame_receiver_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_rx_valid      (rx_valid),
        .o_rx_ready      (rx_ready),
        .i_rx_byte       (rx_byte),
        .o_res_valid     (res_valid),
        .i_res_ready     (res_ready),
        .o_item_kind     (item_kind),
        .o_reg_addr      (reg_addr),
        .o_payload_byte  (payload_byte),
        .o_byte_index    (byte_index),
        .o_payload_len   (payload_len),
        .o_handler_group (handler_group),
        .o_frame_crc     (frame_crc),
        .o_crc_ok        (crc_ok),
        .o_last          (last)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n) begin
            if (rx_valid && rx_ready) begin
                sb.note_input(rx_byte);
            end
            if (res_valid && res_ready) begin
                sb.check_result({item_kind, reg_addr, payload_byte, byte_index, payload_len,
                                 handler_group, frame_crc, crc_ok, last});
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_reg();
        case ($urandom_range(0, 9))
            0: return 8'($urandom_range(8'h21, 8'h26));
            1: return 8'($urandom_range(8'h30, 8'h35));
            2: return 8'($urandom_range(8'h40, 8'h46));
            3: return 8'($urandom_range(8'h50, 8'h54));
            4: return 8'($urandom_range(8'h60, 8'h6C));
            5: return 8'($urandom_range(8'h70, 8'h74));
            6: return 8'($urandom_range(8'hE0, 8'hEF));
            7: return 8'($urandom_range(8'hF0, 8'hFF));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int unsigned gap;
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!rx_ready);
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        rx_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] reg_b, input int unsigned extra_ff,
                              input bit bad_crc);
        logic [CRC_W-1:0]  crc;
        logic [BYTE_W-1:0] len;
        crc = CRC_INIT;
        len = 8'(payload_q.size());
        repeat (extra_ff) send_byte(PREAMBLE_FIRST);
        send_byte(PREAMBLE_FIRST);
        send_byte(PREAMBLE_SECOND);
        send_byte(reg_b);
        crc = sb.crc_step(crc, reg_b);
        send_byte(len);
        crc = sb.crc_step(crc, len);
        foreach (payload_q[k]) begin
            send_byte(payload_q[k]);
            crc = sb.crc_step(crc, payload_q[k]);
        end
        if (bad_crc) begin
            crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        end
        send_byte(crc[15:8]);
        send_byte(crc[7:0]);
        frame_bytes += payload_q.size() + extra_ff + 6;
    endtask

    task automatic fill_payload(input int unsigned len);
        int unsigned roll;
        payload_q.delete();
        repeat (len) begin
            roll = $urandom_range(0, 15);
            if (roll == 0) begin
                payload_q.push_back(PREAMBLE_FIRST);
            end else if (roll == 1) begin
                payload_q.push_back(PREAMBLE_SECOND);
            end else begin
                payload_q.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        int unsigned run;
        int unsigned gap;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                res_ready <= 1'b0;
                repeat (80) @(posedge clk);
            end
            run = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
            res_ready <= 1'b1;
            repeat (run) @(posedge clk);
            gap = pick_gap();
            if (gap > 0) begin
                res_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial begin
        int unsigned roll;
        int unsigned len;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // broken preamble
        send_byte(PREAMBLE_FIRST);
        send_byte(8'h12);
        // repeated FF, zero length
        payload_q.delete();
        send_frame(8'h00, 2, 1'b0);
        // preamble inside payload, bad CRC
        payload_q.delete();
        payload_q.push_back(PREAMBLE_FIRST);
        payload_q.push_back(PREAMBLE_SECOND);
        send_frame(8'h30, 0, 1'b1);
        payload_q.delete();
        payload_q.push_back(PREAMBLE_FIRST);
        send_frame(8'hE5, 0, 1'b0);
        wait_drained();

        // fill the block while the result side holds off
        fill_payload(255);
        tx_steady = 1'b1;
        hold_req  = 1'b1;
        send_frame(pick_reg(), 0, 1'b0);
        tx_steady = 1'b0;
        wait_drained();

        while (frame_bytes < 400) begin
            tx_steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 7) == 0) begin
                send_byte(PREAMBLE_FIRST);
                if ($urandom_range(0, 1) == 0) begin
                    send_byte(8'($urandom_range(0, 8'hA9)));
                end else begin
                    send_byte(8'($urandom_range(8'hAB, 8'hFE)));
                end
            end
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                len = $urandom_range(0, 8);
            end else if (roll < 95) begin
                len = $urandom_range(9, 32);
            end else begin
                len = $urandom_range(33, 80);
            end
            fill_payload(len);
            send_frame(pick_reg(), ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0,
                       $urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### crc_checked_frame_receiver_unit.f
sv/ccfr_pkg.sv
sv/crc_checked_frame_receiver_unit.sv
sv/ccfr_checker.sv
sim/tb.sv
